// File: src/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the framed packet receiver: status codes,
// framing characters, field positions and the decoded packet record.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int PACKET_BYTES_DEF = 61;
  localparam int BODY_BYTES_DEF   = 52;

  // framing characters
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_BANG = 8'h21;

  localparam logic [7:0] RSSI_BIAS = 8'h80;

  // window positions of the decoded fields
  localparam int POS_VERSION = 5;
  localparam int POS_PAN     = 7;
  localparam int POS_TILT    = 11;
  localparam int POS_ROLL    = 15;
  localparam int POS_FOCUS   = 27;
  localparam int POS_IRIS    = 29;
  localparam int POS_ZOOM    = 31;
  localparam int POS_SID     = 51;
  localparam int POS_KNOB1   = 53;
  localparam int POS_KNOB2   = 54;
  localparam int POS_RSSI    = 55;

  localparam int NUM_AXES = 3;

  typedef enum logic [2:0] {
    ST_NOT_READY   = 3'd0,
    ST_GOOD        = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_SIZE    = 3'd3,
    ST_BAD_SUM     = 3'd4
  } fpr_status_e;

  typedef enum logic [1:0] {
    REG_VERSION = 2'd0,
    REG_KNOB1   = 2'd1,
    REG_KNOB2   = 2'd2
  } fpr_reg_e;

  typedef struct packed {
    logic        take;
    logic [31:0] pan;
    logic [31:0] tilt;
    logic [31:0] roll;
    logic [15:0] focus;
    logic [15:0] iris;
    logic [15:0] zoom;
    logic [15:0] sid;
    logic        knob1_match;
    logic        knob2_match;
    logic [7:0]  rssi;
  } fpr_pkt_t;

endpackage

// File: src/framed_packet_receiver_with_offsets.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_with_offsets
// Byte-wide framed packet receiver: a chain of byte cells forms the window,
// a running checksum follows the body, and good packets update positions.
// ----------------------------------------------------------------------------
// An accepted byte is registered into the window and checked; its result is
//   registered at the output. Throughput: one byte per cycle unless stalled;
//   the window chain and running sum advance on each accepted byte; a stalled
//   result stalls the input in the same cycle once a byte waits in the window.
// Reset: window, checksum, session state and fields clear to zero; rssi
//   reads 0 until the first good packet; version register resets to 1.
// ----------------------------------------------------------------------------
module framed_packet_receiver_with_offsets
  import fpr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int BODY_BYTES   = BODY_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] pan_o,
  output logic signed [31:0] tilt_o,
  output logic signed [31:0] roll_o,
  output logic [15:0]        focus_o,
  output logic [15:0]        iris_o,
  output logic [15:0]        zoom_o,
  output logic [15:0]        session_id_o,
  output logic               knob1_echo_o,
  output logic               knob2_echo_o,
  output logic signed [7:0]  rssi_o
);

  localparam int SUM_END = (POS_VERSION + BODY_BYTES > PACKET_BYTES) ?
                           PACKET_BYTES : POS_VERSION + BODY_BYTES;

  logic [7:0]  win_q [PACKET_BYTES];
  logic [7:0]  version_q, knob1_id_q, knob2_id_q;
  logic [7:0]  sum_q, sum_d, enter_byte;
  logic        win_v_q, win_v_d, out_v_q, out_v_d;
  logic        out_free, fire, in_acc;
  logic        hdr_ok, ver_ok, term_ok, sum_ok;
  fpr_status_e status_q, status_d, chk_status;
  fpr_pkt_t    pkt;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q  <= 8'd1;
      knob1_id_q <= '0;
      knob2_id_q <= '0;
    end else if (cfg_we_i) begin
      case (fpr_reg_e'(cfg_idx_i))
        REG_VERSION: version_q  <= cfg_wdata_i;
        REG_KNOB1:   knob1_id_q <= cfg_wdata_i;
        REG_KNOB2:   knob2_id_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake: window holds one unchecked item, output register one result
  assign out_free   = !out_v_q || !out_stall_i;
  assign fire       = win_v_q && out_free;
  assign in_stall_o = win_v_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    win_v_d = win_v_q;
    if (in_acc) begin
      win_v_d = 1'b1;
    end else if (fire) begin
      win_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (fire) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      win_v_q <= win_v_d;
      out_v_q <= out_v_d;
    end
  end

  // window chain: the new byte enters at the far end
  for (genvar i = 0; i < PACKET_BYTES; i++) begin : g_cell
    logic [7:0] cell_d;
    if (i == PACKET_BYTES - 1) begin : g_tail
      assign cell_d = rx_byte_i;
    end else begin : g_mid
      assign cell_d = win_q[i+1];
    end
    fpr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .d_i     (cell_d),
      .q_o     (win_q[i])
    );
  end

  // running body sum: drop the byte leaving the body, add the one entering
  if (SUM_END >= PACKET_BYTES) begin : g_enter_tail
    assign enter_byte = rx_byte_i;
  end else begin : g_enter_mid
    assign enter_byte = win_q[SUM_END];
  end

  assign sum_d = sum_q - win_q[POS_VERSION] + enter_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (in_acc) begin
      sum_q <= sum_d;
    end
  end

  // frame checks on the settled window
  assign hdr_ok  = (win_q[0] == CH_I) && (win_q[1] == CH_W) && (win_q[2] == CH_A) &&
                   (win_q[3] == CH_P) && (win_q[4] == CH_I);
  assign ver_ok  = (win_q[POS_VERSION] == version_q);
  assign term_ok = (win_q[PACKET_BYTES-3] == CH_SEMI) &&
                   (win_q[PACKET_BYTES-2] == CH_BANG) &&
                   (win_q[PACKET_BYTES-1] == CH_SEMI);
  assign sum_ok  = (win_q[PACKET_BYTES-4] == sum_q);

  always_comb begin
    if (!hdr_ok) begin
      chk_status = ST_NOT_READY;
    end else if (!ver_ok) begin
      chk_status = ST_BAD_VERSION;
    end else if (!term_ok) begin
      chk_status = ST_BAD_SIZE;
    end else if (!sum_ok) begin
      chk_status = ST_BAD_SUM;
    end else begin
      chk_status = ST_GOOD;
    end
  end

  always_comb begin
    pkt.take        = fire && (chk_status == ST_GOOD);
    pkt.pan         = {win_q[POS_PAN], win_q[POS_PAN+1], win_q[POS_PAN+2],
                       win_q[POS_PAN+3]};
    pkt.tilt        = {win_q[POS_TILT], win_q[POS_TILT+1], win_q[POS_TILT+2],
                       win_q[POS_TILT+3]};
    pkt.roll        = {win_q[POS_ROLL], win_q[POS_ROLL+1], win_q[POS_ROLL+2],
                       win_q[POS_ROLL+3]};
    pkt.focus       = {win_q[POS_FOCUS], win_q[POS_FOCUS+1]};
    pkt.iris        = {win_q[POS_IRIS], win_q[POS_IRIS+1]};
    pkt.zoom        = {win_q[POS_ZOOM], win_q[POS_ZOOM+1]};
    pkt.sid         = {win_q[POS_SID], win_q[POS_SID+1]};
    pkt.knob1_match = (win_q[POS_KNOB1] == knob1_id_q);
    pkt.knob2_match = (win_q[POS_KNOB2] == knob2_id_q);
    pkt.rssi        = win_q[POS_RSSI];
  end

  assign status_d = fire ? chk_status : status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_NOT_READY;
    end else begin
      status_q <= status_d;
    end
  end

  fpr_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_i         (pkt),
    .pan_o         (pan_o),
    .tilt_o        (tilt_o),
    .roll_o        (roll_o),
    .focus_o       (focus_o),
    .iris_o        (iris_o),
    .zoom_o        (zoom_o),
    .session_id_o  (session_id_o),
    .knob1_echo_o  (knob1_echo_o),
    .knob2_echo_o  (knob2_echo_o),
    .rssi_o        (rssi_o)
  );

  assign out_valid_o = out_v_q;
  assign status_o    = status_q;

endmodule

// File: src/fpr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_cell
// One byte of the receive window; loads its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module fpr_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= d_i;
    end
  end

  assign q_o = byte_q;

endmodule

// File: src/fpr_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_track
// Session tracking: holds offsets, positions, lens fields, knob flags and
// the signal byte of the last good packet, and re-bases offsets on a new session.
// ----------------------------------------------------------------------------
module fpr_track
  import fpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpr_pkt_t           pkt_i,
  output logic signed [31:0] pan_o,
  output logic signed [31:0] tilt_o,
  output logic signed [31:0] roll_o,
  output logic [15:0]        focus_o,
  output logic [15:0]        iris_o,
  output logic [15:0]        zoom_o,
  output logic [15:0]        session_id_o,
  output logic               knob1_echo_o,
  output logic               knob2_echo_o,
  output logic signed [7:0]  rssi_o
);

  logic [15:0] known_q, known_d;
  logic [31:0] shift_q [NUM_AXES];
  logic [31:0] shift_d [NUM_AXES];
  logic [31:0] pos_q   [NUM_AXES];
  logic [31:0] pos_d   [NUM_AXES];
  logic [31:0] raw     [NUM_AXES];
  logic [15:0] focus_q, iris_q, zoom_q, sid_q;
  logic        knob1_q, knob2_q;
  logic [7:0]  rssi_q;
  logic        sid_nz, first_sess, new_sess, same_sess;

  assign raw[0] = pkt_i.pan;
  assign raw[1] = pkt_i.tilt;
  assign raw[2] = pkt_i.roll;

  assign sid_nz     = (pkt_i.sid != '0);
  assign first_sess = sid_nz && (known_q == '0);
  assign new_sess   = sid_nz && (known_q != '0) && (known_q != pkt_i.sid);
  assign same_sess  = (known_q == pkt_i.sid);

  always_comb begin
    known_d = known_q;
    if (pkt_i.take && sid_nz) begin
      known_d = pkt_i.sid;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      shift_d[a] = shift_q[a];
      pos_d[a]   = pos_q[a];
      if (pkt_i.take) begin
        if (first_sess) begin
          // first session: offset cancels the raw value
          shift_d[a] = 32'd0 - raw[a];
          pos_d[a]   = '0;
        end else if (new_sess) begin
          // changed session: hold the last position
          shift_d[a] = pos_q[a] - raw[a];
        end else if (same_sess) begin
          pos_d[a] = raw[a] + shift_q[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= '0;
      focus_q <= '0;
      iris_q  <= '0;
      zoom_q  <= '0;
      sid_q   <= '0;
      knob1_q <= 1'b0;
      knob2_q <= 1'b0;
      rssi_q  <= RSSI_BIAS;
      for (int a = 0; a < NUM_AXES; a++) begin
        shift_q[a] <= '0;
        pos_q[a]   <= '0;
      end
    end else begin
      known_q <= known_d;
      for (int a = 0; a < NUM_AXES; a++) begin
        shift_q[a] <= shift_d[a];
        pos_q[a]   <= pos_d[a];
      end
      if (pkt_i.take) begin
        focus_q <= pkt_i.focus;
        iris_q  <= pkt_i.iris;
        zoom_q  <= pkt_i.zoom;
        sid_q   <= pkt_i.sid;
        rssi_q  <= pkt_i.rssi;
        if (sid_nz) begin
          knob1_q <= pkt_i.knob1_match;
          knob2_q <= pkt_i.knob2_match;
        end
      end
    end
  end

  assign pan_o         = $signed(pos_q[0]);
  assign tilt_o        = $signed(pos_q[1]);
  assign roll_o        = $signed(pos_q[2]);
  assign focus_o       = focus_q;
  assign iris_o        = iris_q;
  assign zoom_o        = zoom_q;
  assign session_id_o  = sid_q;
  assign knob1_echo_o  = knob1_q;
  assign knob2_echo_o  = knob2_q;
  assign rssi_o        = $signed(rssi_q ^ RSSI_BIAS);

endmodule

// File: src/fpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks for the framed packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fpr_checker
  import fpr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic signed [31:0] pan_o,
  input logic [15:0]        focus_o,
  input logic [15:0]        session_id_o
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o))
    else $error("status changed while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_NOT_READY) || (status_o == ST_GOOD) ||
                    (status_o == ST_BAD_VERSION) || (status_o == ST_BAD_SIZE) ||
                    (status_o == ST_BAD_SUM))
    else $error("status code out of range");

  // only a good packet may move the fields
  a_bad_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_GOOD) |->
      $stable(pan_o) && $stable(focus_o) && $stable(session_id_o))
    else $error("fields changed on a bad packet");

endmodule

bind framed_packet_receiver_with_offsets fpr_checker u_fpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .pan_o        (pan_o),
  .focus_o      (focus_o),
  .session_id_o (session_id_o)
);

// File: tb/tb_framed_packet_receiver_with_offsets.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver_with_offsets
// Feeds framed byte packets (good, wrong version, broken terminator, bad sum,
// cut short) mixed with line noise, and checks every status and decoded
// field against a byte-level predictor of the window, the session offsets
// and the held fields. Both handshakes idle at random, and the receiver
// holds off once long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_with_offsets;
  import fpr_pkg::*;

  localparam int NB   = PACKET_BYTES_DEF;
  localparam int BODY = BODY_BYTES_DEF;

  typedef enum int {
    PK_GOOD,
    PK_BAD_VERSION,
    PK_BAD_SIZE,
    PK_BAD_SUM,
    PK_CUT
  } pkt_kind_e;

  typedef struct packed {
    fpr_status_e status;
    logic [31:0] pan;
    logic [31:0] tilt;
    logic [31:0] roll;
    logic [15:0] focus;
    logic [15:0] iris;
    logic [15:0] zoom;
    logic [15:0] sid;
    logic        knob1;
    logic        knob2;
    logic [7:0]  rssi;
  } rx_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = REG_VERSION;
  logic [7:0]         cfg_wdata_i = 8'h00;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i   = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] pan_o;
  logic signed [31:0] tilt_o;
  logic signed [31:0] roll_o;
  logic [15:0]        focus_o;
  logic [15:0]        iris_o;
  logic [15:0]        zoom_o;
  logic [15:0]        session_id_o;
  logic               knob1_echo_o;
  logic               knob2_echo_o;
  logic signed [7:0]  rssi_o;

  // predictor state
  logic [7:0]  rx_window [NB];
  logic [7:0]  ver_reg;
  logic [7:0]  knob1_id;
  logic [7:0]  knob2_id;
  logic [15:0] cur_session;
  logic [31:0] axis_offset [NUM_AXES];
  logic [31:0] axis_pos [NUM_AXES];
  logic [15:0] focus_q;
  logic [15:0] iris_q;
  logic [15:0] zoom_q;
  logic [15:0] sid_q;
  logic [1:0]  knob_ok;
  logic [7:0]  rssi_raw;

  rx_result_t  result_q [$];
  logic [7:0]  byte_q [$];
  rx_result_t  want_r;
  logic [15:0] sid_pick = 16'h0001;

  int errors       = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int results_seen = 0;
  bit calm         = 1'b0;

  framed_packet_receiver_with_offsets u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .pan_o        (pan_o),
    .tilt_o       (tilt_o),
    .roll_o       (roll_o),
    .focus_o      (focus_o),
    .iris_o       (iris_o),
    .zoom_o       (zoom_o),
    .session_id_o (session_id_o),
    .knob1_echo_o (knob1_echo_o),
    .knob2_echo_o (knob2_echo_o),
    .rssi_o       (rssi_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_receiver_model();
    foreach (rx_window[i]) rx_window[i] = 8'h00;
    ver_reg     = 8'h01;
    knob1_id    = 8'h00;
    knob2_id    = 8'h00;
    cur_session = 16'h0000;
    foreach (axis_offset[i]) begin
      axis_offset[i] = 32'h0;
      axis_pos[i]    = 32'h0;
    end
    focus_q  = 16'h0;
    iris_q   = 16'h0;
    zoom_q   = 16'h0;
    sid_q    = 16'h0;
    knob_ok  = 2'b00;
    rssi_raw = RSSI_BIAS;
  endfunction

  function automatic logic [31:0] word_at(int p);
    return {rx_window[p], rx_window[p+1], rx_window[p+2], rx_window[p+3]};
  endfunction

  function automatic fpr_status_e frame_status();
    logic [7:0] sum;
    sum = 8'h00;
    if (rx_window[0] != CH_I || rx_window[1] != CH_W || rx_window[2] != CH_A ||
        rx_window[3] != CH_P || rx_window[4] != CH_I)
      return ST_NOT_READY;
    if (rx_window[POS_VERSION] != ver_reg)
      return ST_BAD_VERSION;
    if (rx_window[NB-3] != CH_SEMI || rx_window[NB-2] != CH_BANG ||
        rx_window[NB-1] != CH_SEMI)
      return ST_BAD_SIZE;
    // body bytes beyond the window add nothing
    for (int k = 0; k < BODY; k++)
      if (k + POS_VERSION < NB) sum += rx_window[k + POS_VERSION];
    return (rx_window[NB-4] == sum) ? ST_GOOD : ST_BAD_SUM;
  endfunction

  // Shift one byte into the window and queue the result it produces.
  function automatic void absorb_byte(logic [7:0] b);
    fpr_status_e st;
    logic [31:0] raw [NUM_AXES];
    logic [15:0] sid;
    rx_result_t  r;
    for (int i = 0; i < NB - 1; i++) rx_window[i] = rx_window[i+1];
    rx_window[NB-1] = b;
    st = frame_status();
    if (st == ST_GOOD) begin
      raw[0]   = word_at(POS_PAN);
      raw[1]   = word_at(POS_TILT);
      raw[2]   = word_at(POS_ROLL);
      sid      = {rx_window[POS_SID], rx_window[POS_SID+1]};
      focus_q  = {rx_window[POS_FOCUS], rx_window[POS_FOCUS+1]};
      iris_q   = {rx_window[POS_IRIS], rx_window[POS_IRIS+1]};
      zoom_q   = {rx_window[POS_ZOOM], rx_window[POS_ZOOM+1]};
      sid_q    = sid;
      rssi_raw = rx_window[POS_RSSI];
      // a new session re-bases offsets: the first starts positions at zero, a changed one continues them
      if (sid != 16'h0 && cur_session != sid) begin
        for (int i = 0; i < NUM_AXES; i++)
          axis_offset[i] = ((cur_session == 16'h0) ? 32'h0 : axis_pos[i]) - raw[i];
        cur_session = sid;
      end
      if (sid != 16'h0)
        knob_ok = {rx_window[POS_KNOB2] == knob2_id, rx_window[POS_KNOB1] == knob1_id};
      if (cur_session == sid)
        for (int i = 0; i < NUM_AXES; i++) axis_pos[i] = raw[i] + axis_offset[i];
    end
    r.status = st;
    r.pan    = axis_pos[0];
    r.tilt   = axis_pos[1];
    r.roll   = axis_pos[2];
    r.focus  = focus_q;
    r.iris   = iris_q;
    r.zoom   = zoom_q;
    r.sid    = sid_q;
    r.knob1  = knob_ok[0];
    r.knob2  = knob_ok[1];
    r.rssi   = rssi_raw ^ RSSI_BIAS;
    result_q.push_back(r);
  endfunction

  function automatic void queue_packet(pkt_kind_e kind, logic [15:0] sid, logic [7:0] k1,
                                       logic [7:0] k2, logic [31:0] pan, logic [31:0] tilt,
                                       logic [31:0] roll);
    logic [7:0] p [NB];
    logic [7:0] sum;
    int cut;
    foreach (p[i]) p[i] = 8'($urandom_range(0, 255));
    {p[0], p[1], p[2], p[3], p[4]} = {CH_I, CH_W, CH_A, CH_P, CH_I};
    p[POS_VERSION] = ver_reg;
    {p[POS_PAN], p[POS_PAN+1], p[POS_PAN+2], p[POS_PAN+3]}     = pan;
    {p[POS_TILT], p[POS_TILT+1], p[POS_TILT+2], p[POS_TILT+3]} = tilt;
    {p[POS_ROLL], p[POS_ROLL+1], p[POS_ROLL+2], p[POS_ROLL+3]} = roll;
    {p[POS_SID], p[POS_SID+1]} = sid;
    p[POS_KNOB1] = k1;
    p[POS_KNOB2] = k2;
    {p[NB-3], p[NB-2], p[NB-1]} = {CH_SEMI, CH_BANG, CH_SEMI};
    sum = 8'h00;
    for (int k = 0; k < BODY; k++)
      if (k + POS_VERSION < NB) sum += p[k + POS_VERSION];
    p[NB-4] = sum;
    case (kind)
      PK_BAD_VERSION: p[POS_VERSION] ^= 8'($urandom_range(1, 255));
      PK_BAD_SIZE:    p[NB - 1 - $urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
      PK_BAD_SUM:     p[NB-4] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    cut = (kind == PK_CUT) ? $urandom_range(1, NB - 1) : NB;
    for (int i = 0; i < cut; i++) byte_q.push_back(p[i]);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly good packets, each with a zero, repeated or newly drawn session, plus noise.
  function automatic int queue_random_packet();
    pkt_kind_e  kind;
    int         r;
    int         start;
    logic [15:0] sid;
    logic [7:0] k1;
    logic [7:0] k2;
    start = byte_q.size();
    r = $urandom_range(0, 99);
    if (r < 60)      kind = PK_GOOD;
    else if (r < 70) kind = PK_BAD_VERSION;
    else if (r < 80) kind = PK_BAD_SIZE;
    else if (r < 90) kind = PK_BAD_SUM;
    else             kind = PK_CUT;
    r = $urandom_range(0, 99);
    if (r < 20) sid = 16'h0000;
    else begin
      if (r >= 60) begin
        case ($urandom_range(0, 2))
          0:       sid_pick = 16'h0001;
          1:       sid_pick = 16'hFFFF;
          default: sid_pick = 16'($urandom_range(1, 65535));
        endcase
      end
      sid = sid_pick;
    end
    k1 = $urandom_range(0, 1) ? knob1_id : 8'($urandom_range(0, 255));
    k2 = $urandom_range(0, 1) ? knob2_id : 8'($urandom_range(0, 255));
    repeat ($urandom_range(0, 6)) byte_q.push_back(8'($urandom_range(0, 255)));
    // false start: a header fragment that never completes
    if ($urandom_range(0, 9) == 0) begin
      byte_q.push_back(CH_I);
      byte_q.push_back(CH_W);
      byte_q.push_back(CH_A);
    end
    queue_packet(kind, sid, k1, k2, pick_word(), pick_word(), pick_word());
    return byte_q.size() - start;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic write_reg(fpr_reg_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_VERSION: ver_reg  = val;
      REG_KNOB1:   knob1_id = val;
      REG_KNOB2:   knob2_id = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || result_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // sender: offer the head of the byte queue, hold it while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_byte(rx_byte_i);
        void'(byte_q.pop_front());
        send_gap = pick_gap();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= byte_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off, early in the run
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      hold_left <= 120;
      hold_done <= 1'b1;
    end
  end

  // receiver: check each item against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("unexpected result item: status %0d", status_o);
          errors++;
        end else begin
          want_r = result_q.pop_front();
          check_field("status", 32'(want_r.status), 32'(status_o));
          check_field("pan", want_r.pan, pan_o);
          check_field("tilt", want_r.tilt, tilt_o);
          check_field("roll", want_r.roll, roll_o);
          check_field("focus", 32'(want_r.focus), 32'(focus_o));
          check_field("iris", 32'(want_r.iris), 32'(iris_o));
          check_field("zoom", 32'(want_r.zoom), 32'(zoom_o));
          check_field("session_id", 32'(want_r.sid), 32'(session_id_o));
          check_field("knob1_echo", 32'(want_r.knob1), 32'(knob1_echo_o));
          check_field("knob2_echo", 32'(want_r.knob2), 32'(knob2_echo_o));
          check_field("rssi", {24'd0, want_r.rssi}, {24'd0, rssi_o});
        end
        results_seen <= results_seen + 1;
      end
      if (recv_gap > 0) recv_gap--;
      else recv_gap = pick_gap();
      out_stall_i <= (recv_gap > 0) || (hold_left > 0);
    end
  end

  initial begin
    int phase_bytes;
    reset_receiver_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset register values, byte extremes, every session case
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h55);
    byte_q.push_back(8'hAA);
    // no session yet: raw positions pass through
    queue_packet(PK_GOOD, 16'h0000, 8'h00, 8'h00,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    // first session: positions read zero
    queue_packet(PK_GOOD, 16'h0001, 8'h00, 8'h07,
                 32'h0000_0001, 32'h1234_5678, 32'h8000_0000);
    queue_packet(PK_GOOD, 16'h0001, 8'h00, 8'h00,
                 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // zero session while one is held: positions and flags stay
    queue_packet(PK_GOOD, 16'h0000, 8'h11, 8'h22,
                 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0000_0042);
    // changed session: positions continue from the held ones
    queue_packet(PK_GOOD, 16'hFFFF, 8'hFF, 8'h00,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_packet(PK_BAD_VERSION, 16'h0002, 8'h00, 8'h00, 32'h1, 32'h2, 32'h3);
    queue_packet(PK_BAD_SIZE, 16'h0002, 8'h00, 8'h00, 32'h4, 32'h5, 32'h6);
    queue_packet(PK_BAD_SUM, 16'h0002, 8'h00, 8'h00, 32'h7, 32'h8, 32'h9);
    queue_packet(PK_CUT, 16'h0002, 8'h00, 8'h00, 32'hA, 32'hB, 32'hC);
    queue_packet(PK_GOOD, 16'hFFFF, 8'h00, 8'h00,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001);

    for (int ph = 0; ph < 3; ph++) begin
      // sender pauses here until every expected item has come back
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_VERSION, 8'hFF);
          write_reg(REG_KNOB1, 8'hFF);
          write_reg(REG_KNOB2, 8'h00);
        end
        1: begin
          write_reg(REG_VERSION, 8'h00);
          write_reg(REG_KNOB1, 8'h00);
          write_reg(REG_KNOB2, 8'hFF);
          calm = 1'b1;
        end
        default: begin
          write_reg(REG_VERSION, 8'($urandom_range(0, 255)));
          write_reg(REG_KNOB1, 8'($urandom_range(0, 255)));
          write_reg(REG_KNOB2, 8'($urandom_range(0, 255)));
          calm = 1'b0;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 20) phase_bytes += queue_random_packet();
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/fpr_pkg.sv
src/fpr_cell.sv
src/fpr_track.sv
src/framed_packet_receiver_with_offsets.sv
src/fpr_checker.sv
tb/tb_framed_packet_receiver_with_offsets.sv
